>>> rtl/itp_pkg.sv
// Shared types, codes and helper functions for the infix-to-postfix converter.
// Used by itp_front, itp_back and infix_to_postfix_converter_top; no dependencies.
package itp_pkg;

	localparam int VALUE_W         = 64;
	localparam int DEF_STACK_DEPTH = 32;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int DEPTH_W         = 7;

	// operator precedence levels
	localparam logic [2:0] PREC_NONE  = 3'd0;
	localparam logic [2:0] PREC_ADD   = 3'd2;
	localparam logic [2:0] PREC_MUL   = 3'd3;
	localparam logic [2:0] PREC_UNARY = 3'd4;
	localparam logic [2:0] PREC_POW   = 3'd5;

	typedef enum logic [3:0] {
		TK_OPEN    = 4'd0,
		TK_CLOSE   = 4'd1,
		TK_PLUS    = 4'd2,
		TK_MINUS   = 4'd3,
		TK_MUL     = 4'd4,
		TK_DIV     = 4'd5,
		TK_CARET   = 4'd6,
		TK_NUMBER  = 4'd7,
		TK_LX      = 4'd8,
		TK_UX      = 4'd9,
		TK_N       = 4'd10,
		TK_SQRT    = 4'd11,
		TK_EXP     = 4'd12,
		TK_END     = 4'd13,
		TK_UNKNOWN = 4'd14
	} token_kind_t;

	typedef enum logic [3:0] {
		NK_NUM  = 4'd0,
		NK_LX   = 4'd1,
		NK_UX   = 4'd2,
		NK_N    = 4'd3,
		NK_ADD  = 4'd4,
		NK_SUB  = 4'd5,
		NK_MUL  = 4'd6,
		NK_DIV  = 4'd7,
		NK_POW  = 4'd8,
		NK_UPLS = 4'd9,
		NK_NEG  = 4'd10,
		NK_SQRT = 4'd11,
		NK_EXP  = 4'd12
	} node_kind_t;

	// stack entry code for an open bracket
	localparam node_kind_t SE_OPEN = NK_NUM;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SYNTAX   = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_UNBAL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		TC_OPEN,
		TC_CLOSE,
		TC_SIGN,
		TC_BINOP,
		TC_OPERAND,
		TC_FUNC,
		TC_END,
		TC_BAD
	} tok_class_t;

	typedef struct packed {
		tok_class_t           cls;
		token_kind_t          kind;
		logic [VALUE_W-1:0]   value;
	} tok_t;

	typedef struct packed {
		logic                 node_valid;
		node_kind_t           node_kind;
		logic [VALUE_W-1:0]   node_value;
		logic                 is_last;
		status_t              status;
	} res_t;

	function automatic logic [2:0] prec_of(input node_kind_t k);
		case (k)
			NK_ADD, NK_SUB:  prec_of = PREC_ADD;
			NK_MUL, NK_DIV:  prec_of = PREC_MUL;
			NK_UPLS, NK_NEG: prec_of = PREC_UNARY;
			NK_POW:          prec_of = PREC_POW;
			default:         prec_of = PREC_NONE;
		endcase
	endfunction

	function automatic logic is_oper(input node_kind_t k);
		is_oper = (k >= NK_ADD) && (k <= NK_NEG);
	endfunction

	function automatic logic is_func(input node_kind_t k);
		is_func = (k == NK_SQRT) || (k == NK_EXP);
	endfunction

endpackage

>>> rtl/itp_front.sv
// Front end: classifies incoming tokens and holds them in a short queue.
// Depends on itp_pkg.
module itp_front #(
	parameter int QUEUE_DEPTH = itp_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  itp_pkg::token_kind_t         in_kind,
	input  logic [itp_pkg::VALUE_W-1:0]  in_value,
	output logic                         tok_valid,
	output itp_pkg::tok_t                tok,
	input  logic                         tok_pop
);
	import itp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tok_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	tok_class_t       cls;
	logic             push, pop;

	always_comb begin
		case (in_kind)
			TK_OPEN:                        cls = TC_OPEN;
			TK_CLOSE:                       cls = TC_CLOSE;
			TK_PLUS, TK_MINUS:              cls = TC_SIGN;
			TK_MUL, TK_DIV, TK_CARET:       cls = TC_BINOP;
			TK_NUMBER, TK_LX, TK_UX, TK_N:  cls = TC_OPERAND;
			TK_SQRT, TK_EXP:                cls = TC_FUNC;
			TK_END:                         cls = TC_END;
			default:                        cls = TC_BAD;
		endcase
	end

	assign in_ready  = (cnt_q != CNT_FULL);
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = tok_pop && tok_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cls: cls, kind: in_kind, value: in_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("token queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> tok_valid)
		else $error("token popped from empty queue");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("token queue count did not advance on push");
`endif

endmodule

>>> rtl/itp_back.sv
// Back end: shunting-yard engine with the operator stack and the result register.
// Depends on itp_pkg; fed by itp_front.
module itp_back #(
	parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  itp_pkg::tok_t  tok,
	output logic           tok_pop,
	output logic           out_valid,
	output itp_pkg::res_t  out_res,
	input  logic           out_ready
);
	import itp_pkg::*;

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(STACK_DEPTH);
	localparam logic [3:0]         PREV_UNARY = 4'd13;
	localparam logic [3:0]         PREV_START = 4'd14;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX  = {DEPTH_W{1'b1}};

	typedef enum logic [2:0] {
		S_TOKEN,
		S_OPER,
		S_CLOSE,
		S_CLOSE_FN,
		S_FLUSH,
		S_STATUS
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [3:0]         prev_q, prev_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	status_t            err_q, err_d;
	node_kind_t         op_q, op_d;
	res_t               out_q;
	logic               out_valid_q;

	node_kind_t         stack_q [STACK_DEPTH];
	node_kind_t         top;
	logic [IDX_W-1:0]   top_idx;
	logic               push_en;
	node_kind_t         push_data;

	logic               emit_ok, emit_en, emit_node;
	res_t               emit_res;
	logic               prev_operand, prev_unary_ok, pop_cond;

	function automatic status_t first_err(input status_t cur, input status_t code);
		first_err = (cur == ST_OK) ? code : cur;
	endfunction

	assign top_idx = IDX_W'(cnt_q - 1'b1);
	assign top     = stack_q[top_idx];
	assign emit_ok = !out_valid_q || out_ready;

	always_comb begin
		prev_operand  = (prev_q == TK_CLOSE) || ((prev_q >= TK_NUMBER) && (prev_q <= TK_N));
		prev_unary_ok = (prev_q == PREV_START) || (prev_q == TK_OPEN)
			|| ((prev_q >= TK_PLUS) && (prev_q <= TK_CARET));
		pop_cond = ((op_q <= NK_DIV) && (prec_of(op_q) == prec_of(top)))
			|| (prec_of(op_q) < prec_of(top));
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		prev_d    = prev_q;
		depth_d   = depth_q;
		err_d     = err_q;
		op_d      = op_q;
		tok_pop   = 1'b0;
		push_en   = 1'b0;
		push_data = op_q;
		emit_en   = 1'b0;
		emit_node = 1'b0;
		emit_res  = '{node_valid: 1'b1, node_kind: top, node_value: '0,
			is_last: 1'b0, status: ST_OK};

		case (state_q)
			S_TOKEN: begin
				if (tok_valid) begin
					if (tok.cls == TC_END) begin
						tok_pop = 1'b1;
						state_d = (err_q == ST_OK) ? S_FLUSH : S_STATUS;
					end else if (err_q != ST_OK) begin
						tok_pop = 1'b1;
					end else begin
						case (tok.cls)
							TC_OPEN, TC_FUNC: begin
								tok_pop   = 1'b1;
								prev_d    = tok.kind;
								push_data = (tok.cls == TC_OPEN) ? SE_OPEN
									: node_kind_t'(tok.kind);
								if (cnt_q == CNT_FULL) begin
									err_d = ST_OVERFLOW;
								end else begin
									push_en = 1'b1;
									cnt_d   = cnt_q + 1'b1;
								end
							end
							TC_OPERAND: begin
								if (emit_ok) begin
									tok_pop   = 1'b1;
									prev_d    = tok.kind;
									emit_en   = 1'b1;
									emit_node = 1'b1;
									emit_res.node_kind = node_kind_t'(tok.kind - TK_NUMBER);
									emit_res.node_value = (tok.kind == TK_NUMBER)
										? tok.value : '0;
								end
							end
							TC_CLOSE: begin
								tok_pop = 1'b1;
								if (cnt_q == '0) begin
									err_d = ST_UNBAL;
								end else begin
									state_d = S_CLOSE;
								end
							end
							TC_SIGN, TC_BINOP: begin
								tok_pop = 1'b1;
								if (prev_operand) begin
									op_d    = node_kind_t'(tok.kind + 4'd2);
									prev_d  = tok.kind;
									state_d = S_OPER;
								end else if ((tok.cls == TC_SIGN) && prev_unary_ok) begin
									op_d    = (tok.kind == TK_PLUS) ? NK_UPLS : NK_NEG;
									prev_d  = PREV_UNARY;
									state_d = S_OPER;
								end else begin
									err_d = ST_SYNTAX;
								end
							end
							default: begin
								tok_pop = 1'b1;
								err_d   = ST_SYNTAX;
							end
						endcase
					end
				end
			end
			S_OPER: begin
				if ((cnt_q != '0) && is_oper(top) && pop_cond) begin
					if (emit_ok) begin
						cnt_d     = cnt_q - 1'b1;
						emit_en   = 1'b1;
						emit_node = 1'b1;
					end
				end else begin
					state_d = S_TOKEN;
					if (cnt_q == CNT_FULL) begin
						err_d = first_err(err_q, ST_OVERFLOW);
					end else begin
						push_en = 1'b1;
						cnt_d   = cnt_q + 1'b1;
					end
				end
			end
			S_CLOSE: begin
				if (cnt_q == '0) begin
					err_d   = first_err(err_q, ST_UNBAL);
					state_d = S_TOKEN;
				end else if (top == SE_OPEN) begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_CLOSE_FN;
				end else if (emit_ok) begin
					cnt_d     = cnt_q - 1'b1;
					emit_en   = 1'b1;
					emit_node = 1'b1;
				end
			end
			S_CLOSE_FN: begin
				if ((cnt_q != '0) && is_func(top)) begin
					if (emit_ok) begin
						cnt_d     = cnt_q - 1'b1;
						emit_en   = 1'b1;
						emit_node = 1'b1;
						prev_d    = TK_CLOSE;
						state_d   = S_TOKEN;
					end
				end else begin
					prev_d  = TK_CLOSE;
					state_d = S_TOKEN;
				end
			end
			S_FLUSH: begin
				if (cnt_q == '0) begin
					if ((err_q == ST_OK) && (depth_q != DEPTH_W'(1))) begin
						err_d = ST_MISMATCH;
					end
					state_d = S_STATUS;
				end else if (top == SE_OPEN) begin
					cnt_d   = cnt_q - 1'b1;
					err_d   = first_err(err_q, ST_UNBAL);
					state_d = S_STATUS;
				end else if (emit_ok) begin
					cnt_d     = cnt_q - 1'b1;
					emit_en   = 1'b1;
					emit_node = 1'b1;
				end
			end
			S_STATUS: begin
				if (emit_ok) begin
					emit_en  = 1'b1;
					emit_res = '{node_valid: 1'b0, node_kind: NK_NUM, node_value: '0,
						is_last: 1'b1, status: err_q};
					cnt_d    = '0;
					prev_d   = PREV_START;
					depth_d  = '0;
					err_d    = ST_OK;
					state_d  = S_TOKEN;
				end
			end
			default: begin
				state_d = S_TOKEN;
			end
		endcase

		// operand-depth check on every emitted node
		if (emit_node) begin
			if (emit_res.node_kind <= NK_N) begin
				if (depth_q == DEPTH_MAX) begin
					err_d = first_err(err_d, ST_MISMATCH);
				end else begin
					depth_d = depth_q + 1'b1;
				end
			end else if (emit_res.node_kind <= NK_POW) begin
				if (depth_q < DEPTH_W'(2)) begin
					err_d = first_err(err_d, ST_MISMATCH);
				end else begin
					depth_d = depth_q - 1'b1;
				end
			end else if (depth_q == '0) begin
				err_d = first_err(err_d, ST_MISMATCH);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_q[cnt_q[IDX_W-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TOKEN;
			cnt_q       <= '0;
			prev_q      <= PREV_START;
			depth_q     <= '0;
			err_q       <= ST_OK;
			op_q        <= NK_ADD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			prev_q  <= prev_d;
			depth_q <= depth_d;
			err_q   <= err_d;
			op_q    <= op_d;
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_q <= emit_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

`ifndef SYNTH
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("operator stack count past depth");
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATUS && emit_ok) |=>
			(cnt_q == '0 && err_q == ST_OK && depth_q == '0 && state_q == S_TOKEN))
		else $error("state not cleared after status word");
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_last) |-> (!out_q.node_valid && out_q.node_kind == NK_NUM))
		else $error("last word carries a node");
`endif

endmodule

>>> rtl/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: stream ports and word packing.
// Depends on itp_pkg, itp_front and itp_back.

// Converts a stream of pre-lexed tokens to postfix nodes by the shunting-yard
// rule, followed by one status word (tlast high) per expression. The front
// end classifies tokens into a QUEUE_DEPTH-entry queue, so s_tready stays high
// while the back end works, as long as that queue has room. In the back end an
// operand, an open bracket, a function or a token dropped after an error is
// handled in the token state alone; an operator passes to the operator state,
// which pops the operators that take precedence over it, then pushes it; a
// close bracket pops the entries above the open bracket and the bracket, then
// emits a pending function; the end token flushes the stack, then sends the
// status word, or goes straight to the status word when an error is already
// pending. The operator stack has a single read port and is popped one entry
// per cycle while the result register is free. Any step that emits a word
// waits while an earlier word is held and m_tready is low. A non-zero status
// on the last word means the nodes of that expression must be discarded. The
// operator stack has no reset or clearing pass; only entries below the stack
// count are read.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH,
	parameter int QUEUE_DEPTH = itp_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] number_value
	input  logic [3:0]  s_tuser,   // [3:0] token_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] node_value, [66:64] status, [71:67] zero
	output logic [4:0]  m_tuser,   // [0] node_valid, [4:1] node_kind
	output logic        m_tlast    // is_last
);
	import itp_pkg::*;

	logic  tok_valid, tok_pop;
	tok_t  tok;
	res_t  res;

	itp_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (token_kind_t'(s_tuser)),
		.in_value  (s_tdata),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop)
	);

	itp_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.out_valid (m_tvalid),
		.out_res   (res),
		.out_ready (m_tready)
	);

	// pack result word
	assign m_tdata = {5'b0, res.status, res.node_value};
	assign m_tuser = {res.node_kind, res.node_valid};
	assign m_tlast = res.is_last;

endmodule
